FILE: hw/rtl/flash_frame_programmer_assert.svh
// Assertion macros used by the checker file of the frame programmer.
`ifndef FLASH_FRAME_PROGRAMMER_ASSERT_SVH
`define FLASH_FRAME_PROGRAMMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FFP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("flash frame programmer check failed");

// Next-cycle implication, disabled while reset is high.
`define FFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("flash frame programmer check failed");

`endif

FILE: hw/rtl/ffp_pkg.sv
`timescale 1ns / 1ps

package ffp_pkg;

  // Default sizes of a flash page and of one programming frame, in bytes.
  localparam int DEF_PAGE_BYTES  = 64;
  localparam int DEF_FRAME_BYTES = 16;

  // Depth of the command queue between front and back end.
  localparam int QUEUE_DEPTH = 4;

  // Register reset values.
  localparam logic [15:0] DEF_BOOT_START = 16'd7168;
  localparam logic [15:0] DEF_VECTOR     = 16'd0;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [15:0] JUMP_OPCODE = 16'hC000;

  // Input modes.
  localparam logic [1:0] MODE_SET_ADDR = 2'd0;
  localparam logic [1:0] MODE_DATA     = 2'd1;
  localparam logic [1:0] MODE_CHECK    = 2'd2;
  localparam logic [1:0] MODE_ERASE    = 2'd3;

  // Flash operations on the result stream.
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_FILL  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_ERASE = 2'd3;

  // Command kinds held in the queue.
  localparam logic [1:0] CMD_FILL  = 2'd0;
  localparam logic [1:0] CMD_CHECK = 2'd1;
  localparam logic [1:0] CMD_ERASE = 2'd2;

  // Register indexes on the configuration port.
  localparam logic REG_BOOT_START = 1'b0;
  localparam logic REG_VECTOR     = 1'b1;

  // One classified command: everything the back end needs to emit its results.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;   // fill address, or page start of a write
    logic [15:0] word;   // fill word, or jump opcode for an erase
    logic        ok;     // frame check passed
    logic        wr;     // frame check is preceded by a page write
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [15:0] word;
    logic        sv;
    logic        ok;
    logic        last;
  } result_t;

  // Reflected CRC-16 update over one byte.
  function automatic logic [15:0] ffp_crc16_byte(input logic [15:0] crc_in,
                                                  input logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

  // CRC-16 update over one word, low byte first.
  function automatic logic [15:0] ffp_crc16_word(input logic [15:0] crc_in,
                                                  input logic [15:0] data);
    logic [15:0] crc;
    crc = ffp_crc16_byte(crc_in, data[7:0]);
    crc = ffp_crc16_byte(crc, data[15:8]);
    return crc;
  endfunction

  // Relative jump from the reset vector into the boot section.
  function automatic logic [15:0] ffp_jump_word(input logic [15:0] boot_start);
    logic [15:0] offset;
    offset = (boot_start >> 1) - 16'd1;
    return JUMP_OPCODE | offset;
  endfunction

endpackage

FILE: hw/rtl/ffp_front.sv
`timescale 1ns / 1ps

module ffp_front #(
  parameter int PAGE_BYTES  = ffp_pkg::DEF_PAGE_BYTES,
  parameter int FRAME_BYTES = ffp_pkg::DEF_FRAME_BYTES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [15:0]        s_tdata,   // data_word
  input  logic [1:0]         s_tuser,   // mode
  input  logic [15:0]        boot_start_address,
  input  logic [15:0]        vector_address,
  input  logic               q_full,
  output logic               q_push,
  output ffp_pkg::cmd_t      q_cmd
);
  import ffp_pkg::*;

  localparam int FRAME_WORDS = (FRAME_BYTES + 1) / 2;
  localparam int CNT_W       = $clog2(FRAME_WORDS + 1);
  localparam logic [15:0] PAGE_MASK = 16'(PAGE_BYTES - 1);
  localparam logic [15:0] PAGE_SPAN = 16'(PAGE_BYTES);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(FRAME_WORDS);

  logic [15:0]      page_address;
  logic [15:0]      frame_address;
  logic [15:0]      running_crc;
  logic [CNT_W-1:0] words_in_frame;

  logic             accept;
  logic             first_word;
  logic             frame_full;
  logic [15:0]      crc_base;
  logic [15:0]      crc_next;
  logic [15:0]      fill_addr;
  logic [15:0]      fill_word;
  logic [15:0]      jump;
  logic             crc_match;
  logic [15:0]      page_start;
  logic             write_page;

  // An item is taken whenever the queue has room for its command.
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // Data word path: the first word of a frame restarts CRC and address.
  assign first_word = (words_in_frame == '0);
  assign frame_full = (words_in_frame == FULL_COUNT);
  assign crc_base   = first_word ? CRC_INIT : running_crc;
  assign fill_addr  = first_word ? page_address : frame_address;
  assign crc_next   = ffp_crc16_word(crc_base, s_tdata);
  assign jump       = ffp_jump_word(boot_start_address);
  assign fill_word  = (fill_addr == vector_address) ? jump : s_tdata;

  // Check word path: a complete frame with a matching CRC is accepted.
  assign crc_match  = frame_full && (running_crc == s_tdata);
  assign page_start = frame_address - PAGE_SPAN;
  assign write_page = crc_match && ((frame_address & PAGE_MASK) == 16'd0) &&
                      (page_start < boot_start_address);

  // Classify the item into a queue command.
  always_comb begin
    q_push     = 1'b0;
    q_cmd.kind = CMD_FILL;
    q_cmd.addr = fill_addr;
    q_cmd.word = fill_word;
    q_cmd.ok   = 1'b0;
    q_cmd.wr   = 1'b0;
    unique case (s_tuser)
      MODE_SET_ADDR: begin
        q_push = 1'b0;
      end
      MODE_DATA: begin
        q_push = accept && !frame_full;
      end
      MODE_CHECK: begin
        q_push     = accept;
        q_cmd.kind = CMD_CHECK;
        q_cmd.addr = page_start;
        q_cmd.word = 16'd0;
        q_cmd.ok   = crc_match;
        q_cmd.wr   = write_page;
      end
      MODE_ERASE: begin
        q_push     = accept;
        q_cmd.kind = CMD_ERASE;
        q_cmd.addr = 16'd0;
        q_cmd.word = jump;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  // Frame and page state.
  always_ff @(posedge clk) begin
    if (rst) begin
      page_address   <= 16'd0;
      frame_address  <= 16'd0;
      running_crc    <= CRC_INIT;
      words_in_frame <= '0;
    end else if (accept) begin
      case (s_tuser)
        MODE_SET_ADDR: begin
          page_address   <= s_tdata & ~PAGE_MASK;
          words_in_frame <= '0;
        end
        MODE_DATA: begin
          if (!frame_full) begin
            running_crc    <= crc_next;
            frame_address  <= fill_addr + 16'd2;
            words_in_frame <= words_in_frame + 1'b1;
          end
        end
        MODE_CHECK: begin
          words_in_frame <= '0;
          if (crc_match) begin
            page_address <= frame_address;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/ffp_queue.sv
`timescale 1ns / 1ps

module ffp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ffp_pkg::cmd_t push_cmd,
  input  logic          pop,
  output ffp_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);
  import ffp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W:0] DEPTH_COUNT = (PTR_W + 1)'(QUEUE_DEPTH);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign empty = (count == '0);
  assign full  = (count == DEPTH_COUNT);
  assign head  = entries[rd_ptr];

  // Command storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/ffp_back.sv
`timescale 1ns / 1ps

module ffp_back (
  input  logic          clk,
  input  logic          rst,
  input  ffp_pkg::cmd_t head,
  input  logic          empty,
  output logic          pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [39:0]   m_tdata,   // flash_address, flash_word, frame_ok, zero fill
  output logic [2:0]    m_tuser,   // flash_op, status_valid
  output logic          m_tlast    // last
);
  import ffp_pkg::*;

  logic [1:0] step;
  logic       load;
  result_t    res;
  result_t    out_reg;

  // Expand the head command into its result items, one per step.
  always_comb begin
    res = '0;
    unique case (head.kind)
      CMD_FILL: begin
        res.op   = OP_FILL;
        res.addr = head.addr;
        res.word = head.word;
        res.last = 1'b1;
      end
      CMD_CHECK: begin
        if (head.wr && step == 2'd0) begin
          res.op   = OP_WRITE;
          res.addr = head.addr;
        end else begin
          res.sv   = 1'b1;
          res.ok   = head.ok;
          res.last = 1'b1;
        end
      end
      CMD_ERASE: begin
        if (step == 2'd0) begin
          res.op = OP_ERASE;
        end else if (step == 2'd1) begin
          res.op   = OP_FILL;
          res.word = head.word;
        end else begin
          res.op   = OP_WRITE;
          res.last = 1'b1;
        end
      end
      default: begin
        res.last = 1'b1;
      end
    endcase
  end

  // Output register takes a new result whenever it is empty or being drained.
  assign load = !empty && (!m_tvalid || m_tready);
  assign pop  = load && res.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      step     <= 2'd0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        step <= 2'd0;
      end else if (load) begin
        step <= step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_reg <= res;
    end
  end

  assign m_tdata = {7'd0, out_reg.ok, out_reg.word, out_reg.addr};
  assign m_tuser = {out_reg.sv, out_reg.op};
  assign m_tlast = out_reg.last;

endmodule

FILE: hw/rtl/flash_frame_programmer.sv
`timescale 1ns / 1ps

// Command engine of a page-programming bootloader. Each input transaction carries a mode in
// s_tuser and a 16-bit word in s_tdata; results leave as flash operations (fill, page write,
// erase) and frame status. A front end accepts one transaction per cycle as long as its
// four-entry command queue has room, updating page, frame and CRC-16 state in that cycle;
// address-set transactions and data words past a full frame yield no result. A back end
// drains the queue through a registered output stage at one result per cycle while m_tready
// is high: a data word yields one result, a CRC check one or two, an erase three. Sustained
// throughput is therefore one transaction per cycle for data words, limited by the
// back end's single output register for checks and erases. PAGE_BYTES must be a power
// of two. The two configuration registers are to be written over the APB port only while
// no transaction is in flight; the block itself does not enforce this.
module flash_frame_programmer #(
  parameter int PAGE_BYTES  = ffp_pkg::DEF_PAGE_BYTES,
  parameter int FRAME_BYTES = ffp_pkg::DEF_FRAME_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // data_word
  input  logic [1:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // flash_address, flash_word, frame_ok, zero fill
  output logic [2:0]  m_tuser,   // flash_op, status_valid
  output logic        m_tlast,   // last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ffp_pkg::*;

  logic [15:0] boot_start_address;
  logic [15:0] vector_address;
  logic        cfg_write;
  logic        q_push;
  cmd_t        q_cmd;
  logic        q_pop;
  cmd_t        q_head;
  logic        q_empty;
  logic        q_full;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      boot_start_address <= DEF_BOOT_START;
      vector_address     <= DEF_VECTOR;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_BOOT_START: boot_start_address <= pwdata[15:0];
        REG_VECTOR:     vector_address     <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  assign prdata = {16'd0, (paddr[2] == REG_VECTOR) ? vector_address : boot_start_address};

  ffp_front #(
    .PAGE_BYTES (PAGE_BYTES),
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .s_tvalid          (s_tvalid),
    .s_tready          (s_tready),
    .s_tdata           (s_tdata),
    .s_tuser           (s_tuser),
    .boot_start_address(boot_start_address),
    .vector_address    (vector_address),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_cmd             (q_cmd)
  );

  ffp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(q_cmd),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty),
    .full    (q_full)
  );

  ffp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_head),
    .empty   (q_empty),
    .pop     (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

FILE: hw/rtl/ffp_checker.sv
`timescale 1ns / 1ps
`include "flash_frame_programmer_assert.svh"

module ffp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);
  import ffp_pkg::*;

  // A stalled result keeps its contents.
  `FFP_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // A frame status ends its transaction and carries no flash operation.
  `FFP_ASSERT_IMPLY(a_status_last, clk, rst, m_tvalid && m_tuser[2],
    m_tlast && (m_tuser[1:0] == OP_NONE))

  // Without a status the frame result bit stays low.
  `FFP_ASSERT_IMPLY(a_ok_needs_status, clk, rst, m_tvalid && !m_tuser[2], !m_tdata[32])

  // An erase is at address zero and is not the last result; its fill and page write follow.
  `FFP_ASSERT_IMPLY(a_erase_not_last, clk, rst, m_tvalid && (m_tuser[1:0] == OP_ERASE),
    !m_tlast && (m_tdata[15:0] == 16'd0))

endmodule

bind flash_frame_programmer ffp_checker u_ffp_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);

FILE: tb/flash_op_checker.sv
`timescale 1ns / 1ps

// Watches both streams and the register port of the frame programmer. It keeps its own copy
// of the page, frame and CRC state, works out the flash operations that each accepted
// transaction must cause, and compares every result transaction against the oldest of them.
module flash_op_checker #(
  parameter int PAGE_BYTES  = ffp_pkg::DEF_PAGE_BYTES,
  parameter int FRAME_BYTES = ffp_pkg::DEF_FRAME_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // data_word
  input  logic [1:0]  s_tuser,   // mode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // flash_address, flash_word, frame_ok, zero fill
  input  logic [2:0]  m_tuser,   // flash_op, status_valid
  input  logic        m_tlast,   // last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count,
  output int          ops_pending,
  output int          results_seen
);

  import ffp_pkg::*;

  localparam int          FRAME_WORDS = (FRAME_BYTES + 1) / 2;
  localparam logic [15:0] IN_PAGE     = 16'(PAGE_BYTES - 1);

  // Register copies and frame state as the block should hold them.
  logic [15:0] boot_start;
  logic [15:0] vector_addr;
  logic [15:0] page_base;
  logic [15:0] frame_addr;
  logic [15:0] crc_acc;
  int          frame_words;

  // Flash operations that are owed by the block, oldest first.
  result_t ops_due[$];

  function automatic result_t make_op(input logic [1:0] op, input logic [15:0] addr,
                                      input logic [15:0] word, input logic sv,
                                      input logic ok, input logic last);
    result_t r;
    r.op   = op;
    r.addr = addr;
    r.word = word;
    r.sv   = sv;
    r.ok   = ok;
    r.last = last;
    return r;
  endfunction

  // Reflected CRC-16 over a whole word. Feeding the word at once is the same as feeding the
  // low byte and then the high byte, since the high byte cannot reach bit 0 in the first
  // eight shifts.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [15:0] word);
    logic [15:0] c;
    c = crc ^ word;
    for (int k = 0; k < 16; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Relative jump from the reset vector into the boot section.
  function automatic logic [15:0] boot_jump(input logic [15:0] boot);
    logic [15:0] offset;
    offset = (boot >> 1) - 16'd1;
    return JUMP_OPCODE | offset;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  // Updates the frame state for one accepted command and queues the operations it owes.
  task automatic predict_flash_ops(input logic [1:0] mode, input logic [15:0] word);
    logic [15:0] fill_word;
    logic [15:0] page_start;
    logic        crc_ok;
    case (mode)
      MODE_SET_ADDR: begin
        page_base   = word & ~IN_PAGE;
        frame_words = 0;
      end
      MODE_DATA: begin
        // Words beyond a full frame are dropped without a result.
        if (frame_words < FRAME_WORDS) begin
          if (frame_words == 0) begin
            crc_acc    = CRC_INIT;
            frame_addr = page_base;
          end
          crc_acc   = crc_fold(crc_acc, word);
          fill_word = (frame_addr == vector_addr) ? boot_jump(boot_start) : word;
          ops_due.push_back(make_op(OP_FILL, frame_addr, fill_word, 1'b0, 1'b0, 1'b1));
          frame_addr  = frame_addr + 16'd2;
          frame_words = frame_words + 1;
        end
      end
      MODE_CHECK: begin
        crc_ok      = (frame_words >= FRAME_WORDS) && (crc_acc == word);
        frame_words = 0;
        if (crc_ok) begin
          page_base = frame_addr;
          // A frame that closes a page writes it, unless the page is in the boot section.
          if ((frame_addr & IN_PAGE) == 16'd0) begin
            page_start = frame_addr - 16'(PAGE_BYTES);
            if (page_start < boot_start) begin
              ops_due.push_back(make_op(OP_WRITE, page_start, 16'd0, 1'b0, 1'b0, 1'b0));
            end
          end
        end
        ops_due.push_back(make_op(OP_NONE, 16'd0, 16'd0, 1'b1, crc_ok, 1'b1));
      end
      default: begin
        ops_due.push_back(make_op(OP_ERASE, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0));
        ops_due.push_back(make_op(OP_FILL, 16'd0, boot_jump(boot_start), 1'b0, 1'b0, 1'b0));
        ops_due.push_back(make_op(OP_WRITE, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1));
      end
    endcase
  endtask

  always @(posedge clk) begin
    result_t seen;
    result_t due;
    if (rst) begin
      boot_start  = DEF_BOOT_START;
      vector_addr = DEF_VECTOR;
      page_base   = 16'd0;
      frame_addr  = 16'd0;
      crc_acc     = CRC_INIT;
      frame_words = 0;
      ops_due.delete();
    end else begin
      // Register writes update the copies; reads must return them.
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == {REG_BOOT_START, 2'b00}) begin
            boot_start = pwdata[15:0];
          end else if (paddr == {REG_VECTOR, 2'b00}) begin
            vector_addr = pwdata[15:0];
          end
        end else if (paddr == {REG_BOOT_START, 2'b00}) begin
          check_field("boot_start_address readback", {16'd0, boot_start}, prdata);
        end else if (paddr == {REG_VECTOR, 2'b00}) begin
          check_field("vector_address readback", {16'd0, vector_addr}, prdata);
        end
      end

      if (s_tvalid && s_tready) begin
        predict_flash_ops(s_tuser, s_tdata);
      end

      // Each result transaction is matched to the oldest owed operation.
      if (m_tvalid && m_tready) begin
        seen = make_op(m_tuser[1:0], m_tdata[15:0], m_tdata[31:16], m_tuser[2],
                       m_tdata[32], m_tlast);
        if (ops_due.size() == 0) begin
          $error("unexpected result: flash_op %0d, flash_address %h", seen.op, seen.addr);
          fail_count++;
        end else begin
          due = ops_due.pop_front();
          check_field("flash_op", 32'(due.op), 32'(seen.op));
          check_field("flash_address", 32'(due.addr), 32'(seen.addr));
          check_field("flash_word", 32'(due.word), 32'(seen.word));
          check_field("status_valid", 32'(due.sv), 32'(seen.sv));
          check_field("frame_ok", 32'(due.ok), 32'(seen.ok));
          check_field("last", 32'(due.last), 32'(seen.last));
          results_seen++;
        end
      end
    end
    ops_pending = ops_due.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import ffp_pkg::*;

  localparam int          FRAME_WORDS = (DEF_FRAME_BYTES + 1) / 2;
  localparam logic [15:0] IN_PAGE     = 16'(DEF_PAGE_BYTES - 1);
  localparam int          QUIET_LIMIT = 2000;
  localparam int          STALL_CYCLES = 60;

  typedef enum int {FRAME_GOOD, FRAME_BAD_CRC, FRAME_SHORT, FRAME_LONG} frame_kind_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // data_word
  logic [1:0]  s_tuser;   // mode
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // flash_address, flash_word, frame_ok, zero fill
  logic [2:0]  m_tuser;   // flash_op, status_valid
  logic        m_tlast;   // last
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int ops_pending;
  int results_seen;
  int items_sent;
  int extras_sent;
  int quiet_cycles;
  bit no_idle;
  bit stall_req;

  flash_frame_programmer dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  flash_op_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .fail_count  (fail_count),
    .ops_pending (ops_pending),
    .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The CRC a well-formed frame must carry in its check word.
  function automatic logic [15:0] frame_crc_fold(input logic [15:0] crc,
                                                 input logic [15:0] word);
    logic [15:0] c;
    c = crc ^ word;
    for (int k = 0; k < 16; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Data words lean toward the extremes now and then.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Addresses near the patched vector, in the low application area, or anywhere.
  function automatic logic [15:0] pick_address(input logic [15:0] hot_page);
    case ($urandom_range(0, 2))
      0: return hot_page | 16'($urandom_range(0, DEF_PAGE_BYTES - 1));
      1: return 16'($urandom_range(0, 16'h1FFF));
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one command after a random gap and returns at the edge that accepts it.
  task automatic send(input logic [1:0] mode, input logic [15:0] word);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= word;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    items_sent++;
  endtask

  // Sends a frame of data words and its check word, well formed or broken on purpose.
  task automatic send_frame(input frame_kind_t kind);
    logic [15:0] crc;
    logic [15:0] word;
    int          count;
    crc   = CRC_INIT;
    count = (kind == FRAME_SHORT) ? $urandom_range(0, FRAME_WORDS - 1) : FRAME_WORDS;
    repeat (count) begin
      word = pick_word();
      crc  = frame_crc_fold(crc, word);
      send(MODE_DATA, word);
    end
    if (kind == FRAME_LONG) begin
      repeat ($urandom_range(1, 3)) begin
        send(MODE_DATA, pick_word());
        extras_sent++;
      end
    end
    if (kind == FRAME_BAD_CRC) begin
      crc = crc ^ (16'd1 << $urandom_range(0, 15));
    end
    send(MODE_CHECK, crc);
  endtask

  // Stops offering and waits until every owed result has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (ops_pending != 0);
    repeat (10) @(posedge clk);
  endtask

  // One register port transaction: setup cycle, then access cycle.
  task automatic apb_access(input logic wr, input logic idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic, mostly well-formed frames. Under pressure the sink stalls while a
  // burst of frames goes in without gaps.
  task automatic random_traffic(input int quota, input logic [15:0] hot_page,
                                input bit pressure, input bit calm_start);
    int start_count;
    int done;
    start_count = items_sent - extras_sent;
    done        = 0;
    if (pressure) begin
      stall_req = 1'b1;
      no_idle   = 1'b1;
      repeat (2) send_frame(FRAME_GOOD);
      no_idle = 1'b0;
      done    = items_sent - extras_sent - start_count;
    end
    while (done < quota) begin
      no_idle = calm_start && (done < 40);
      case ($urandom_range(0, 19))
        0, 1, 2: send(MODE_SET_ADDR, pick_address(hot_page));
        13:      send_frame(FRAME_LONG);
        14, 15:  send_frame(FRAME_BAD_CRC);
        16:      send_frame(FRAME_SHORT);
        17:      send(MODE_ERASE, pick_word());
        18, 19:  send(2'($urandom_range(0, 3)), pick_word());
        default: send_frame(FRAME_GOOD);
      endcase
      done = items_sent - extras_sent - start_count;
    end
    no_idle = 1'b0;
  endtask

  // Result sink: random stalls per transaction, plus one long hold-off on request.
  initial begin
    int gap;
    m_tready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (stall_req) begin
        m_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_req = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(negedge clk); while (!m_tvalid);
      @(posedge clk);
    end
  end

  // Watchdog: ends the run when no transaction of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [15:0] boot_cfg;
    logic [15:0] vector_cfg;
    int          phase;
    s_tvalid <= 1'b0;
    s_tdata  <= 16'd0;
    s_tuser  <= MODE_SET_ADDR;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= 3'd0;
    pwdata   <= 32'd0;
    no_idle   = 1'b0;
    stall_req = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: masked address, early checks with no and with some words, erase,
    // a frame over the reset vector with words past its end, and a corrupted check word.
    send(MODE_SET_ADDR, 16'hFFFF);
    send(MODE_CHECK, 16'h0000);
    send(MODE_DATA, 16'hFFFF);
    send(MODE_CHECK, 16'hFFFF);
    send(MODE_ERASE, 16'h0000);
    send(MODE_SET_ADDR, 16'h0000);
    send_frame(FRAME_LONG);
    send_frame(FRAME_BAD_CRC);

    // Random traffic under several register settings, extremes included.
    for (phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          boot_cfg   = DEF_BOOT_START;
          vector_cfg = DEF_VECTOR;
        end
        1: begin
          boot_cfg   = 16'hFFFF;
          vector_cfg = 16'hFFFE;
        end
        2: begin
          boot_cfg   = 16'h0000;
          vector_cfg = 16'($urandom_range(0, 16'h1FFF)) & 16'hFFFE;
        end
        default: begin
          boot_cfg   = 16'($urandom);
          vector_cfg = 16'($urandom);
        end
      endcase
      apb_access(1'b1, REG_BOOT_START, boot_cfg);
      apb_access(1'b1, REG_VECTOR, vector_cfg);
      apb_access(1'b0, REG_BOOT_START, 16'd0);
      apb_access(1'b0, REG_VECTOR, 16'd0);
      random_traffic(65, vector_cfg & ~IN_PAGE, phase == 0, phase == 1);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d commands (%0d words past a full frame) under four register settings.",
             items_sent, extras_sent);
    $display("Compared %0d flash operations: fills, page writes, erases and frame status.",
             results_seen);
    if (fail_count == 0 && ops_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
